// ===== rtl/core/acps_pkg.sv =====
package acps_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int LEVEL_SCALE = 297;
   localparam int PROD_W      = SAMPLE_BITS + 9;
   localparam int LEVEL_W     = PROD_W - SAMPLE_BITS - 1;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;
   localparam int TIME_W      = 32;
   localparam int DUTY_W      = 10;
   localparam int TMO_W       = 16;

   localparam logic [2:0] REG_LIMIT    = 3'd0;
   localparam logic [2:0] REG_TIMEOUT  = 3'd1;
   localparam logic [2:0] REG_OFF_THR  = 3'd2;
   localparam logic [2:0] REG_ON_THR   = 3'd3;
   localparam logic [2:0] REG_LOW_THR  = 3'd4;

   localparam logic [1:0]        RST_LIMIT   = 2'd3;
   localparam logic [TMO_W-1:0]  RST_TIMEOUT = 16'd5000;
   localparam logic [7:0]        RST_OFF_THR = 8'd110;
   localparam logic [7:0]        RST_ON_THR  = 8'd80;
   localparam logic [7:0]        RST_LOW_THR = 8'd20;

   localparam logic [DUTY_W-1:0] DUTY_16A    = 10'd266;
   localparam logic [DUTY_W-1:0] DUTY_32A    = 10'd533;
   localparam logic [DUTY_W-1:0] DUTY_63A    = 10'd892;
   localparam logic [DUTY_W-1:0] DUTY_STEADY = 10'd1000;

   localparam logic [1:0] LIMIT_16A = 2'd0;
   localparam logic [1:0] LIMIT_32A = 2'd1;
   localparam logic [1:0] LIMIT_63A = 2'd2;

   localparam int FLT_UNPLUGGED  = 0;
   localparam int FLT_READY_TO   = 1;
   localparam int FLT_RELEASE_TO = 2;

   localparam logic [2:0] CODE_IDLE     = 3'd0;
   localparam logic [2:0] CODE_START    = 3'd1;
   localparam logic [2:0] CODE_STARTING = 3'd2;
   localparam logic [2:0] CODE_CHARGING = 3'd3;
   localparam logic [2:0] CODE_STOPPING = 3'd4;
   localparam logic [2:0] CODE_STOP     = 3'd5;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2
   } act_type;

   typedef enum logic [5:0] {
      MODE_IDLE     = 6'b000001,
      MODE_START    = 6'b000010,
      MODE_STARTING = 6'b000100,
      MODE_CHARGING = 6'b001000,
      MODE_STOPPING = 6'b010000,
      MODE_STOP     = 6'b100000
   } mode_type;

   typedef enum logic [2:0] {
      PH_ARM  = 3'b001,
      PH_WAIT = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0]       current_limit_mode;
      logic [TMO_W-1:0] ready_timeout_ms;
      logic [7:0]       connect_off_threshold;
      logic [7:0]       connect_on_threshold;
      logic [7:0]       ready_low_threshold;
   } cfg_type;

   typedef struct packed {
      act_type                action;
      logic [SAMPLE_BITS-1:0] pilot_sample;
      logic [TIME_W-1:0]      time_now;
   } item_type;

   typedef struct packed {
      logic conn;
      logic rdy;
   } pilot_type;

   typedef struct packed {
      logic [2:0]        channel_mode;
      logic [DUTY_W-1:0] pwm_compare;
      logic              relay_closed;
      logic              plug_connected;
      logic              vehicle_ready;
      logic              connect_changed;
      logic              fault_unplugged_at_start;
      logic              fault_ready_timeout;
      logic              fault_release_timeout;
      logic              command_accepted;
   } rsp_type;

   function automatic logic [DUTY_W-1:0] duty_for(input logic [1:0] limit);
      logic [DUTY_W-1:0] duty;
      case (limit)
         LIMIT_16A: duty = DUTY_16A;
         LIMIT_32A: duty = DUTY_32A;
         LIMIT_63A: duty = DUTY_63A;
         default:   duty = DUTY_STEADY;
      endcase
      return duty;
   endfunction

endpackage

// ===== rtl/core/acps_csr.sv =====
module acps_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [acps_pkg::ADDR_W-1:0] paddr,
   input  logic [acps_pkg::DATA_W-1:0] pwdata,
   output logic [acps_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output acps_pkg::cfg_type           cfg
);
   import acps_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[ADDR_W-1:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_LIMIT:   cfg_in.current_limit_mode    = pwdata[1:0];
            REG_TIMEOUT: cfg_in.ready_timeout_ms      = pwdata[TMO_W-1:0];
            REG_OFF_THR: cfg_in.connect_off_threshold = pwdata[7:0];
            REG_ON_THR:  cfg_in.connect_on_threshold  = pwdata[7:0];
            REG_LOW_THR: cfg_in.ready_low_threshold   = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_LIMIT:   prdata = DATA_W'(cfg_ff.current_limit_mode);
         REG_TIMEOUT: prdata = DATA_W'(cfg_ff.ready_timeout_ms);
         REG_OFF_THR: prdata = DATA_W'(cfg_ff.connect_off_threshold);
         REG_ON_THR:  prdata = DATA_W'(cfg_ff.connect_on_threshold);
         REG_LOW_THR: prdata = DATA_W'(cfg_ff.ready_low_threshold);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_limit_mode    <= RST_LIMIT;
         cfg_ff.ready_timeout_ms      <= RST_TIMEOUT;
         cfg_ff.connect_off_threshold <= RST_OFF_THR;
         cfg_ff.connect_on_threshold  <= RST_ON_THR;
         cfg_ff.ready_low_threshold   <= RST_LOW_THR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/acps_classify.sv =====
module acps_classify (
   input  logic [acps_pkg::SAMPLE_BITS-1:0] sample,
   input  acps_pkg::cfg_type                cfg,
   output acps_pkg::pilot_type              pilot
);
   import acps_pkg::*;

   logic [PROD_W-1:0]  product;
   logic [LEVEL_W-1:0] level;

   // level = (s * 297) >> (SAMPLE_BITS + 1)
   assign product = PROD_W'(sample) * PROD_W'(LEVEL_SCALE);
   assign level   = product[PROD_W-1:SAMPLE_BITS+1];

   always_comb begin
      if (level >= cfg.connect_off_threshold) begin
         pilot = '{conn: 1'b0, rdy: 1'b0};
      end else if (level >= cfg.connect_on_threshold) begin
         pilot = '{conn: 1'b1, rdy: 1'b0};
      end else if (level >= cfg.ready_low_threshold) begin
         pilot = '{conn: 1'b1, rdy: 1'b1};
      end else begin
         pilot = '{conn: 1'b0, rdy: 1'b0};
      end
   end

endmodule

// ===== rtl/core/acps_seq.sv =====
module acps_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  acps_pkg::item_type item,
   input  acps_pkg::cfg_type  cfg,
   output acps_pkg::rsp_type  rsp
);
   import acps_pkg::*;

   mode_type          mode_ff, mode_in, req;
   phase_type         phase_ff, phase_in;
   logic [TIME_W-1:0] stamp_ff, stamp_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic              relay_ff, relay_in;
   logic              conn_ff, conn_in;
   logic              rdy_ff, rdy_in;
   logic [2:0]        fault_ff, fault_in;
   logic              changed_ff, changed_in;
   logic              accepted_ff, accepted_in;
   logic [TIME_W-1:0] elapsed;
   logic              timed_out;
   pilot_type         pilot;
   logic [2:0]        mode_code;

   acps_classify u_classify (
      .sample (item.pilot_sample),
      .cfg    (cfg),
      .pilot  (pilot)
   );

   assign elapsed   = item.time_now - stamp_ff;
   assign timed_out = elapsed >= TIME_W'(cfg.ready_timeout_ms);

   always_comb begin
      req         = mode_ff;
      phase_in    = phase_ff;
      stamp_in    = stamp_ff;
      duty_in     = duty_ff;
      relay_in    = relay_ff;
      conn_in     = conn_ff;
      rdy_in      = rdy_ff;
      fault_in    = fault_ff;
      changed_in  = 1'b0;
      accepted_in = 1'b0;
      unique case (item.action)
         ACT_TICK: begin
            conn_in    = pilot.conn;
            rdy_in     = pilot.rdy;
            changed_in = pilot.conn != conn_ff;
            unique case (mode_ff)
               MODE_START: begin
                  if (pilot.conn) begin
                     req = MODE_STARTING;
                  end else begin
                     fault_in[FLT_UNPLUGGED] = 1'b1;
                     req = MODE_STOPPING;
                  end
               end
               MODE_STARTING: begin
                  unique case (phase_ff)
                     PH_ARM: begin
                        duty_in  = duty_for(cfg.current_limit_mode);
                        phase_in = PH_WAIT;
                        stamp_in = item.time_now;
                     end
                     PH_WAIT: begin
                        if (timed_out) begin
                           fault_in[FLT_READY_TO] = 1'b1;
                           req = MODE_STOPPING;
                        end else if (pilot.rdy) begin
                           relay_in = 1'b1;
                           req = MODE_CHARGING;
                        end
                     end
                     default: ;
                  endcase
               end
               MODE_STOPPING: begin
                  unique case (phase_ff)
                     PH_ARM: begin
                        phase_in = PH_WAIT;
                        stamp_in = item.time_now;
                     end
                     PH_WAIT: begin
                        if (timed_out) begin
                           fault_in[FLT_RELEASE_TO] = 1'b1;
                           relay_in = 1'b0;
                           phase_in = PH_DONE;
                        end else if (!pilot.rdy) begin
                           relay_in = 1'b0;
                           phase_in = PH_DONE;
                        end
                     end
                     PH_DONE: begin
                        duty_in = DUTY_STEADY;
                        req = MODE_STOP;
                     end
                     default: ;
                  endcase
               end
               MODE_STOP: req = MODE_IDLE;
               default: ;
            endcase
         end
         ACT_START: begin
            if (mode_ff == MODE_IDLE) begin
               req = MODE_START;
               accepted_in = 1'b1;
            end
         end
         ACT_STOP: begin
            if (mode_ff == MODE_START || mode_ff == MODE_STARTING ||
                mode_ff == MODE_CHARGING) begin
               req = MODE_STOPPING;
               accepted_in = 1'b1;
            end
         end
         default: ;
      endcase
      mode_in = req;
      if (req != mode_ff) begin
         phase_in = PH_ARM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         phase_ff <= PH_ARM;
         stamp_ff <= '0;
         duty_ff  <= DUTY_STEADY;
         relay_ff <= 1'b0;
         conn_ff  <= 1'b0;
         rdy_ff   <= 1'b0;
         fault_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         stamp_ff <= stamp_in;
         duty_ff  <= duty_in;
         relay_ff <= relay_in;
         conn_ff  <= conn_in;
         rdy_ff   <= rdy_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         changed_ff  <= changed_in;
         accepted_ff <= accepted_in;
      end
   end

   always_comb begin
      unique case (mode_ff)
         MODE_IDLE:     mode_code = CODE_IDLE;
         MODE_START:    mode_code = CODE_START;
         MODE_STARTING: mode_code = CODE_STARTING;
         MODE_CHARGING: mode_code = CODE_CHARGING;
         MODE_STOPPING: mode_code = CODE_STOPPING;
         MODE_STOP:     mode_code = CODE_STOP;
         default:       mode_code = CODE_IDLE;
      endcase
   end

   assign rsp.channel_mode             = mode_code;
   assign rsp.pwm_compare              = duty_ff;
   assign rsp.relay_closed             = relay_ff;
   assign rsp.plug_connected           = conn_ff;
   assign rsp.vehicle_ready            = rdy_ff;
   assign rsp.connect_changed          = changed_ff;
   assign rsp.fault_unplugged_at_start = fault_ff[FLT_UNPLUGGED];
   assign rsp.fault_ready_timeout      = fault_ff[FLT_READY_TO];
   assign rsp.fault_release_timeout    = fault_ff[FLT_RELEASE_TO];
   assign rsp.command_accepted         = accepted_ff;

`ifndef SYNTHESIS
   a_relay_mode: assert property (@(posedge clock) disable iff (reset)
      relay_ff |-> (mode_ff == MODE_CHARGING || mode_ff == MODE_STOPPING))
      else $error("relay closed outside charging or stopping");

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(fault_ff) & ~fault_ff) == 3'b000))
      else $error("fault bit cleared without reset");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(mode_ff) && $stable(phase_ff) && $stable(duty_ff)))
      else $error("state moved without a beat");

   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (mode_ff == MODE_STOPPING))
      else $error("release phase outside stopping");
`endif

endmodule

// ===== rtl/core/ac_charger_pilot_sequencer_core.sv =====
// AC charging pilot sequencer.
// Request channel (req_valid/req_ready): one beat per action: periodic tick
// carrying a pilot ADC sample and millisecond time, or a start / stop command.
// Response channel (rsp_valid/rsp_ready): exactly one beat per request beat,
// in order, with channel mode, PWM compare, relay drive, pilot class,
// connect-change flag, sticky faults and command-accepted flag.
// Config: APB-style port, registers at byte address 4*i (limit mode, ready
// timeout, off / on / low pilot thresholds); pready is tied high. Write only
// while the block is idle.
// A request is accepted into the input register; the state update is a
// step from the input register into the state/result registers. Throughput:
// one beat per cycle while the output is free (empty or rsp_ready high).
// Stalls: while rsp_ready is low the response holds, one more beat is held in
// the input register, then req_ready drops.
// Reset (synchronous): mode idle, duty 1000, relay open, faults clear,
// registers to defaults, both channels empty.
module ac_charger_pilot_sequencer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic [acps_pkg::SAMPLE_BITS-1:0] req_pilot_sample,
   input  logic [acps_pkg::TIME_W-1:0]      req_time_now,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_channel_mode,
   output logic [acps_pkg::DUTY_W-1:0]      rsp_pwm_compare,
   output logic                             rsp_relay_closed,
   output logic                             rsp_plug_connected,
   output logic                             rsp_vehicle_ready,
   output logic                             rsp_connect_changed,
   output logic                             rsp_fault_unplugged_at_start,
   output logic                             rsp_fault_ready_timeout,
   output logic                             rsp_fault_release_timeout,
   output logic                             rsp_command_accepted,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [acps_pkg::ADDR_W-1:0]      paddr,
   input  logic [acps_pkg::DATA_W-1:0]      pwdata,
   output logic [acps_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);
   import acps_pkg::*;

   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff;
   logic     out_valid_ff, out_valid_in;
   logic     step;
   logic     take;
   cfg_type  cfg;
   rsp_type  rsp;

   acps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || !out_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.action       <= act_type'(req_action);
         in_item_ff.pilot_sample <= req_pilot_sample;
         in_item_ff.time_now     <= req_time_now;
      end
   end

   acps_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .cfg   (cfg),
      .rsp   (rsp)
   );

   assign rsp_valid                    = out_valid_ff;
   assign rsp_channel_mode             = rsp.channel_mode;
   assign rsp_pwm_compare              = rsp.pwm_compare;
   assign rsp_relay_closed             = rsp.relay_closed;
   assign rsp_plug_connected           = rsp.plug_connected;
   assign rsp_vehicle_ready            = rsp.vehicle_ready;
   assign rsp_connect_changed          = rsp.connect_changed;
   assign rsp_fault_unplugged_at_start = rsp.fault_unplugged_at_start;
   assign rsp_fault_ready_timeout      = rsp.fault_ready_timeout;
   assign rsp_fault_release_timeout    = rsp.fault_release_timeout;
   assign rsp_command_accepted         = rsp.command_accepted;

endmodule
